// ----- hw/rtl/kdslp_pkg.sv -----
// Shared types, constants and helpers for the key debounce / press classifier.
package kdslp_pkg;

    localparam int KEY_COUNT  = 4;
    localparam int CNT_W      = 8;
    localparam int CODE_W     = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CNT_W-1:0] SAT_MAX = 8'hfe;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS       = 2'd3;

    localparam logic [CNT_W-1:0] RST_PRESS_DEBOUNCE   = 8'd3;
    localparam logic [CNT_W-1:0] RST_RELEASE_DEBOUNCE = 8'd3;
    localparam logic [CNT_W-1:0] RST_SHORT_TICKS      = 8'd5;
    localparam logic [CNT_W-1:0] RST_LONG_TICKS       = 8'd100;

    localparam logic [CODE_W-1:0] EVT_NONE = 4'd0;

    typedef struct packed {
        logic [CNT_W-1:0] press_debounce;
        logic [CNT_W-1:0] release_debounce;
        logic [CNT_W-1:0] short_ticks;
        logic [CNT_W-1:0] long_ticks;
    } t_cfg;

    // What one lane reports for the current item
    typedef struct packed {
        logic fire;       // release confirmed with a reportable duration
        logic long_press; // duration at or above the long threshold
        logic pressed;    // debounced state after this item
    } t_lane_res;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v >= SAT_MAX) ? SAT_MAX : v + 8'd1;
    endfunction

endpackage

// ----- hw/rtl/kdslp_lane.sv -----
// One key's debounce counters, debounced state and press-duration tracker.
module kdslp_lane (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_level,
    input  kdslp_pkg::t_cfg        i_cfg,
    output kdslp_pkg::t_lane_res   o_res
);

    logic [kdslp_pkg::CNT_W-1:0] r_press_cnt,   n_press_cnt;
    logic [kdslp_pkg::CNT_W-1:0] r_release_cnt, n_release_cnt;
    logic [kdslp_pkg::CNT_W-1:0] r_duration,    n_duration;
    logic                        r_pressed,     n_pressed;
    logic                        w_fire;
    logic                        w_long;

    always_comb begin
        n_press_cnt   = r_press_cnt;
        n_release_cnt = r_release_cnt;
        n_duration    = r_duration;
        n_pressed     = r_pressed;
        w_fire        = 1'b0;
        w_long        = 1'b0;
        if (!i_level) begin
            n_release_cnt = '0;
            n_press_cnt   = kdslp_pkg::sat_inc(r_press_cnt);
            if (n_press_cnt > i_cfg.press_debounce) begin
                n_pressed  = 1'b1;
                n_duration = kdslp_pkg::sat_inc(r_duration);
            end
        end else begin
            n_press_cnt   = '0;
            n_release_cnt = kdslp_pkg::sat_inc(r_release_cnt);
            if (n_release_cnt > i_cfg.release_debounce) begin
                n_pressed  = 1'b0;
                // a zero short threshold acts as one
                w_fire     = (r_duration != '0) && (r_duration >= i_cfg.short_ticks);
                w_long     = r_duration >= i_cfg.long_ticks;
                n_duration = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_cnt   <= '0;
            r_release_cnt <= '0;
            r_duration    <= '0;
            r_pressed     <= 1'b0;
        end else if (i_accept) begin
            r_press_cnt   <= n_press_cnt;
            r_release_cnt <= n_release_cnt;
            r_duration    <= n_duration;
            r_pressed     <= n_pressed;
        end
    end

    assign o_res.fire       = w_fire;
    assign o_res.long_press = w_long;
    assign o_res.pressed    = n_pressed;

endmodule

// ----- hw/rtl/kdslp_merge.sv -----
// Merges lane results into one event code and mask, held in the output register.
module kdslp_merge (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_accept,
    input  kdslp_pkg::t_lane_res [kdslp_pkg::KEY_COUNT-1:0] i_res,
    input  logic                                           i_ready,
    output logic                                           o_valid,
    output logic [kdslp_pkg::CODE_W-1:0]                   o_event_code,
    output logic [kdslp_pkg::KEY_COUNT-1:0]                o_debounced_mask
);

    logic                               r_valid, n_valid;
    logic [kdslp_pkg::CODE_W-1:0]       r_code,  n_code;
    logic [kdslp_pkg::KEY_COUNT-1:0]    r_mask,  n_mask;

    // ascending scan: the highest firing key overwrites the rest
    always_comb begin
        n_code = kdslp_pkg::EVT_NONE;
        for (int k = 0; k < kdslp_pkg::KEY_COUNT; k++) begin
            n_mask[k] = i_res[k].pressed;
            if (i_res[k].fire) begin
                n_code = kdslp_pkg::CODE_W'(2 * k + 1 + int'(i_res[k].long_press));
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_code <= n_code;
            r_mask <= n_mask;
        end
    end

    assign o_valid          = r_valid;
    assign o_event_code     = r_code;
    assign o_debounced_mask = r_mask;

endmodule

// ----- hw/rtl/key_debounce_short_long_press_core.sv -----
// Top level: config registers, per-key lanes and the result merge stage.
//
//  channel | signals                              | accepted when
//  --------+--------------------------------------+---------------------------
//  in      | i_valid, o_ready, i_key_levels       | i_valid & o_ready
//  out     | o_valid, i_ready, o_event_code,      | o_valid & i_ready
//          | o_debounced_mask                     |
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data    | i_cfg_we
//
// One item per cycle: every key lane updates its counters in the cycle the
// item is accepted, and the merged result appears in the output register on
// the next cycle. The output register frees as it is read, so
// o_ready only drops while a result is held and i_ready is low.
// Synchronous active-low reset clears all key state and loads the register
// defaults 3, 3, 5 and 100.
module key_debounce_short_long_press_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [kdslp_pkg::KEY_COUNT-1:0]     i_key_levels,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [kdslp_pkg::CODE_W-1:0]        o_event_code,
    output logic [kdslp_pkg::KEY_COUNT-1:0]     o_debounced_mask,
    input  logic                                i_cfg_we,
    input  logic [kdslp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kdslp_pkg::CNT_W-1:0]         i_cfg_data
);

    kdslp_pkg::t_cfg                                 r_cfg;
    kdslp_pkg::t_lane_res [kdslp_pkg::KEY_COUNT-1:0] w_res;
    logic                                            w_accept;
    logic [kdslp_pkg::CODE_W-1:0]                    w_evt_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_debounce   <= kdslp_pkg::RST_PRESS_DEBOUNCE;
            r_cfg.release_debounce <= kdslp_pkg::RST_RELEASE_DEBOUNCE;
            r_cfg.short_ticks      <= kdslp_pkg::RST_SHORT_TICKS;
            r_cfg.long_ticks       <= kdslp_pkg::RST_LONG_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kdslp_pkg::CFG_PRESS_DEBOUNCE:   r_cfg.press_debounce   <= i_cfg_data;
                kdslp_pkg::CFG_RELEASE_DEBOUNCE: r_cfg.release_debounce <= i_cfg_data;
                kdslp_pkg::CFG_SHORT_TICKS:      r_cfg.short_ticks      <= i_cfg_data;
                kdslp_pkg::CFG_LONG_TICKS:       r_cfg.long_ticks       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready  = !o_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    for (genvar g = 0; g < kdslp_pkg::KEY_COUNT; g++) begin : g_lane
        kdslp_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (w_accept),
            .i_level  (i_key_levels[g]),
            .i_cfg    (r_cfg),
            .o_res    (w_res[g])
        );
    end

    kdslp_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_res            (w_res),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_event_code     (o_event_code),
        .o_debounced_mask (o_debounced_mask)
    );

    // key index behind a non-zero event code
    assign w_evt_idx = (o_event_code - 4'd1) >> 1;

    a_accept_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted item produced no result");

    a_code_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_code <= 4'(2 * kdslp_pkg::KEY_COUNT)))
        else $error("event code out of range");

    a_event_key_released : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_code != kdslp_pkg::EVT_NONE))
            |-> !o_debounced_mask[w_evt_idx[1:0]])
        else $error("event reported for a key still debounced as pressed");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the key debounce / short-long press core.
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [1:0] RDY_FREE   = 2'd0;
    localparam logic [1:0] RDY_JITTER = 2'd1;
    localparam logic [1:0] RDY_CHOKE  = 2'd2;

    typedef struct packed {
        logic [kdslp_pkg::CODE_W-1:0]    code;
        logic [kdslp_pkg::KEY_COUNT-1:0] mask;
    } t_scan_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_ready;
    logic [kdslp_pkg::KEY_COUNT-1:0]    i_key_levels = '1;
    logic                               o_valid;
    logic                               i_ready = 1'b0;
    logic [kdslp_pkg::CODE_W-1:0]       o_event_code;
    logic [kdslp_pkg::KEY_COUNT-1:0]    o_debounced_mask;
    logic                               i_cfg_we = 1'b0;
    logic [kdslp_pkg::CFG_IDX_W-1:0]    i_cfg_index = kdslp_pkg::CFG_PRESS_DEBOUNCE;
    logic [kdslp_pkg::CNT_W-1:0]        i_cfg_data = '0;

    key_debounce_short_long_press_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_key_levels     (i_key_levels),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_event_code     (o_event_code),
        .o_debounced_mask (o_debounced_mask),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Local copy of the scanner: thresholds and per-key counters
    logic [kdslp_pkg::CNT_W-1:0] cfg_press_db   = kdslp_pkg::RST_PRESS_DEBOUNCE;
    logic [kdslp_pkg::CNT_W-1:0] cfg_release_db = kdslp_pkg::RST_RELEASE_DEBOUNCE;
    logic [kdslp_pkg::CNT_W-1:0] cfg_short      = kdslp_pkg::RST_SHORT_TICKS;
    logic [kdslp_pkg::CNT_W-1:0] cfg_long       = kdslp_pkg::RST_LONG_TICKS;
    logic [kdslp_pkg::CNT_W-1:0] prs_cnt [kdslp_pkg::KEY_COUNT] = '{default: '0};
    logic [kdslp_pkg::CNT_W-1:0] rel_cnt [kdslp_pkg::KEY_COUNT] = '{default: '0};
    logic [kdslp_pkg::CNT_W-1:0] hold_dur [kdslp_pkg::KEY_COUNT] = '{default: '0};
    logic                        held [kdslp_pkg::KEY_COUNT] = '{default: 1'b0};

    t_scan_result pending_results[$];
    int           mismatches = 0;

    int burst_left = 1;

    // Per-key level scripts for the random phases
    logic [kdslp_pkg::KEY_COUNT-1:0] script_levels = '1;
    int                              script_left [kdslp_pkg::KEY_COUNT];

    function automatic logic [kdslp_pkg::CNT_W-1:0] bump(
        input logic [kdslp_pkg::CNT_W-1:0] v);
        return (v >= kdslp_pkg::SAT_MAX) ? kdslp_pkg::SAT_MAX : v + 1'b1;
    endfunction

    function automatic t_scan_result step_keys(input logic [kdslp_pkg::KEY_COUNT-1:0] lv);
        t_scan_result                r;
        logic [kdslp_pkg::CNT_W-1:0] min_short;
        r.code = kdslp_pkg::EVT_NONE;
        r.mask = '0;
        min_short = (cfg_short == 0) ? 8'd1 : cfg_short;
        for (int k = 0; k < kdslp_pkg::KEY_COUNT; k++) begin
            if (!lv[k]) begin
                rel_cnt[k] = '0;
                prs_cnt[k] = bump(prs_cnt[k]);
                if (prs_cnt[k] > cfg_press_db) begin
                    held[k] = 1'b1;
                    hold_dur[k] = bump(hold_dur[k]);
                end
            end else begin
                prs_cnt[k] = '0;
                rel_cnt[k] = bump(rel_cnt[k]);
                if (rel_cnt[k] > cfg_release_db) begin
                    held[k] = 1'b0;
                    // later keys overwrite earlier ones: highest index wins
                    if (hold_dur[k] >= min_short)
                        r.code = (hold_dur[k] < cfg_long)
                                 ? kdslp_pkg::CODE_W'(2 * k + 1)
                                 : kdslp_pkg::CODE_W'(2 * k + 2);
                    hold_dur[k] = '0;
                end
            end
            r.mask[k] = held[k];
        end
        return r;
    endfunction

    // Sender: bursts of items with idle gaps in between
    task automatic send_scan(input logic [kdslp_pkg::KEY_COUNT-1:0] lv);
        int gap;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_key_levels <= lv;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(step_keys(lv));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(150, 50)
                                                  : $urandom_range(12, 1);
            gap = $urandom_range(10, 1);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kdslp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kdslp_pkg::CNT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            kdslp_pkg::CFG_PRESS_DEBOUNCE:   cfg_press_db = val;
            kdslp_pkg::CFG_RELEASE_DEBOUNCE: cfg_release_db = val;
            kdslp_pkg::CFG_SHORT_TICKS:      cfg_short = val;
            kdslp_pkg::CFG_LONG_TICKS:       cfg_long = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [kdslp_pkg::CNT_W-1:0] p,
                              input logic [kdslp_pkg::CNT_W-1:0] r,
                              input logic [kdslp_pkg::CNT_W-1:0] s,
                              input logic [kdslp_pkg::CNT_W-1:0] l);
        drain();
        write_reg(kdslp_pkg::CFG_PRESS_DEBOUNCE, p);
        write_reg(kdslp_pkg::CFG_RELEASE_DEBOUNCE, r);
        write_reg(kdslp_pkg::CFG_SHORT_TICKS, s);
        write_reg(kdslp_pkg::CFG_LONG_TICKS, l);
    endtask

    // Each key toggles after runs of random length: bounce-length runs or, at a
    // given share, long holds; a share of items replaced with random levels.
    task automatic run_key_scripts(input int n_items, input int pct_long, input int run_lo,
                                   input int run_hi, input int pct_noise);
        logic [kdslp_pkg::KEY_COUNT-1:0] lv;
        foreach (script_left[k]) script_left[k] = 0;
        for (int i = 0; i < n_items; i++) begin
            for (int k = 0; k < kdslp_pkg::KEY_COUNT; k++) begin
                if (script_left[k] == 0) begin
                    script_levels[k] = ~script_levels[k];
                    script_left[k] = ($urandom_range(99) < pct_long)
                                     ? $urandom_range(run_hi, run_lo) : $urandom_range(3, 1);
                end
                script_left[k]--;
            end
            lv = ($urandom_range(99) < pct_noise) ? kdslp_pkg::KEY_COUNT'($urandom)
                                                  : script_levels;
            send_scan(lv);
        end
    endtask

    // All keys held then released together at reset thresholds
    task automatic test_reset_values;
        repeat (8) send_scan('0);
        repeat (4) send_scan('1);
    endtask

    task automatic test_directed_edges;
        // zero short time acts as one tick
        set_config(8'd0, 8'd0, 8'd0, 8'd2);
        send_scan(4'b1110);
        send_scan(4'b1111);
        send_scan(4'b1111);     // repeated release, nothing left to report
        repeat (3) send_scan(4'b0111);
        send_scan(4'b1111);     // long press of top key, largest code
        // zero long time: everything is long
        set_config(8'd0, 8'd0, 8'd1, 8'd0);
        send_scan(4'b1101);
        send_scan(4'b1111);
        // press debounce at saturation never confirms
        set_config(8'd254, 8'd0, 8'd1, 8'd1);
        repeat (3) send_scan(4'b0000);
        send_scan(4'b1111);
    endtask

    task automatic test_random_defaults;
        set_config(kdslp_pkg::RST_PRESS_DEBOUNCE, kdslp_pkg::RST_RELEASE_DEBOUNCE,
                   kdslp_pkg::RST_SHORT_TICKS, kdslp_pkg::RST_LONG_TICKS);
        run_key_scripts(300, 30, 4, 120, 10);
    endtask

    task automatic test_random_fast;
        repeat (5) begin
            set_config(8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(6)),
                       8'($urandom_range(12)));
            run_key_scripts(60, 40, 1, 15, 10);
        end
    endtask

    // Holds around 254 ticks: counters and durations saturate
    task automatic test_saturation;
        set_config(8'd0, 8'd0, 8'd254, 8'd254);
        run_key_scripts(400, 70, 250, 270, 0);
    endtask

    task automatic test_unconfirmable;
        set_config(8'd255, 8'd254, 8'd1, 8'd1);
        run_key_scripts(40, 50, 1, 10, 50);
        set_config(8'd253, 8'd255, 8'd255, 8'd255);
        run_key_scripts(40, 50, 1, 10, 50);
    endtask

    // Receiver: ready pattern switches between free, jittery and choked
    logic [1:0] rdy_mode = RDY_FREE;
    int         rdy_cycle = 0;
    int         stall_left = 0;

    always @(negedge i_clk) begin
        if (rdy_cycle == 0) begin
            rdy_mode <= 2'($urandom_range(2));
            rdy_cycle <= 99;
        end else begin
            rdy_cycle <= rdy_cycle - 1;
        end
        if (stall_left != 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            case (rdy_mode)
                RDY_JITTER: stall_left <= ($urandom_range(1) == 0) ? $urandom_range(3, 1) : 0;
                RDY_CHOKE:  stall_left <= $urandom_range(20, 5);
                default:    stall_left <= 0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_scan_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item: code %0d mask %b", $time,
                         o_event_code, o_debounced_mask);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_event_code !== want.code) begin
                    $display("%0t: event_code expected %0d actual %0d", $time,
                             want.code, o_event_code);
                    mismatches++;
                end
                if (o_debounced_mask !== want.mask) begin
                    $display("%0t: debounced_mask expected %b actual %b", $time,
                             want.mask, o_debounced_mask);
                    mismatches++;
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress, giving up", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_directed_edges();
        test_random_defaults();
        test_random_fast();
        test_saturation();
        test_unconfirmable();
        drain();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
